// ===== rtl/core/gpa_pkg.sv =====
// Shared types and constants for the GF(2^8) parity accumulate unit.
package gpa_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_LENGTH  = 2048;
  localparam int ROW_W       = 3;
  localparam int TIDX_W      = 5;
  localparam int OFF_W       = 11;
  localparam int NIB_W       = 4;
  localparam int NIB_ENTRIES = 16;
  localparam int WORD_W      = MAX_ROWS * 8;
  localparam int ACT_W       = 4;
  localparam int S_DATA_W    = 32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_PRESET = 2'd1,
    CMD_ACCUM  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } b_state_t;

  // One decoded command as it waits in the queue.
  typedef struct packed {
    cmd_t                cmd;
    logic [ROW_W-1:0]    row;
    logic [TIDX_W-1:0]   tidx;
    logic [OFF_W-1:0]    offset;
    logic [7:0]          data;
    logic [MAX_ROWS-1:0] row_sel;
  } op_t;

endpackage

// ===== rtl/core/gpa_front.sv =====
// Front end: accepts command beats, decodes them and queues them for execution.
module gpa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gpa_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         pop,
  output logic                         q_valid,
  output gpa_pkg::op_t                 head
);
  import gpa_pkg::*;

  op_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  op_t               dec;

  // tdata: command [1:0], row [4:2], table_index [9:5], offset [20:10], data_byte [28:21]
  always_comb begin
    dec.cmd     = cmd_t'(s_tdata[1:0]);
    dec.row     = s_tdata[4:2];
    dec.tidx    = s_tdata[9:5];
    dec.offset  = s_tdata[20:10];
    dec.data    = s_tdata[28:21];
    dec.row_sel = MAX_ROWS'(1) << s_tdata[4:2];
  end

  assign s_tready = (count != QCNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign head     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - QCNT_W'(1)))
    else $error("queue count did not shrink on pop");

endmodule

// ===== rtl/core/gpa_back.sv =====
// Back end: nibble tables, parity store and the read-modify-write sequencer.
module gpa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gpa_pkg::ACT_W-1:0]   cfg_data,
  input  logic                        q_valid,
  input  gpa_pkg::op_t                head,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata
);
  import gpa_pkg::*;

  b_state_t          state;
  b_state_t          state_next;
  op_t               op;
  logic [ACT_W-1:0]  active_rows;
  logic              rd_en;
  logic              out_free;
  logic              out_load;
  logic              tab_we;
  logic              par_we;
  logic [WORD_W-1:0] par_rd;
  logic [WORD_W-1:0] par_wdata;
  logic [WORD_W-1:0] product;
  logic [WORD_W-1:0] preset_mask;
  logic [WORD_W-1:0] par_mem [MAX_LENGTH];

  assign out_free = !m_tvalid || m_tready;
  assign rd_en    = (state == B_IDLE) && q_valid;
  assign pop      = rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= ACT_W'(1);
    end else if (cfg_we) begin
      active_rows <= cfg_data;
    end
  end

  // One low-nibble and one high-nibble product table per row.
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    logic [7:0] lo_tab [NIB_ENTRIES];
    logic [7:0] hi_tab [NIB_ENTRIES];
    logic [7:0] lo_rd;
    logic [7:0] hi_rd;
    logic       row_we;

    assign row_we = tab_we && (op.row == ROW_W'(r));

    always_ff @(posedge clk) begin
      if (row_we && !op.tidx[TIDX_W-1]) begin
        lo_tab[op.tidx[NIB_W-1:0]] <= op.data;
      end
      if (row_we && op.tidx[TIDX_W-1]) begin
        hi_tab[op.tidx[NIB_W-1:0]] <= op.data;
      end
      if (rd_en) begin
        lo_rd <= lo_tab[head.data[NIB_W-1:0]];
        hi_rd <= hi_tab[head.data[7:NIB_W]];
      end
    end

    assign product[r*8 +: 8]     = (ACT_W'(r) < active_rows) ? (lo_rd ^ hi_rd) : 8'h00;
    assign preset_mask[r*8 +: 8] = {8{op.row_sel[r]}};
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[op.offset] <= par_wdata;
    end
    if (rd_en) begin
      par_rd <= par_mem[head.offset];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tab_we     = 1'b0;
    par_we     = 1'b0;
    out_load   = 1'b0;
    par_wdata  = par_rd ^ product;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        state_next = B_IDLE;
        unique case (op.cmd)
          CMD_LOAD: begin
            tab_we = 1'b1;
          end
          CMD_PRESET: begin
            par_we    = 1'b1;
            par_wdata = (par_rd & ~preset_mask) | ({MAX_ROWS{op.data}} & preset_mask);
          end
          CMD_ACCUM: begin
            par_we = 1'b1;
          end
          CMD_READ: begin
            // hold until the output register frees up
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              state_next = B_EXEC;
            end
          end
          default: begin
            state_next = B_IDLE;
          end
        endcase
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= par_rd[{op.row, 3'b000} +: 8];
    end
  end

  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == B_EXEC && op.cmd == CMD_READ && out_free) |=> m_tvalid)
    else $error("read result not presented");

  a_exec_retires: assert property (@(posedge clk) disable iff (rst)
    (state == B_EXEC && !(op.cmd == CMD_READ && !out_free)) |=> (state == B_IDLE))
    else $error("command did not retire");

  a_no_write_on_issue: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (!par_we && !tab_we))
    else $error("memory write collides with issue read");

endmodule

// ===== rtl/core/gf256_parity_accumulate_unit.sv =====
// Top level of the GF(2^8) split-table parity accumulate unit.
//
// Commands arrive as beats on the s_ channel: load a nibble-table byte, preset
// a parity byte, accumulate a source byte into all active rows at an offset,
// or read a parity byte. Only a read produces a beat on the m_ channel.
// The active row count is written through cfg_we / cfg_data; the user must do
// so only while idle, which the block itself does not enforce.
// Accepted beats enter a four-deep queue. The execution sequencer takes one
// command at a time, as the parity store's read-modify-write needs: in IDLE it
// reads the parity word and the table entries (registered memory reads), in
// EXEC it writes the updated word back. A read's result is loaded into the
// output register in EXEC and shows on m_tvalid; if the output register is
// not free, EXEC holds until it is.
//
// Reset empties the queue and the output register and sets active rows to 1;
// table and parity contents are undefined until written.
// When the receiver holds m_tready low, the result stays in the output
// register, the sequencer holds on the next read, the queue fills and
// s_tready drops.
module gf256_parity_accumulate_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gpa_pkg::ACT_W-1:0]    cfg_data,   // active_rows
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // command [1:0], row [4:2], table_index [9:5], offset [20:10], data_byte [28:21]
  input  logic [gpa_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata     // parity_value [7:0]
);
  import gpa_pkg::*;

  op_t  head;
  logic q_valid;
  logic pop;

  gpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  gpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/gf256_parity_accumulate_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the GF(2^8) split-table parity accumulate unit.
module gf256_parity_accumulate_unit_tb;
  import gpa_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BEATS  = 45;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    cmd_t              cmd;
    logic [ROW_W-1:0]  row;
    logic [TIDX_W-1:0] tidx;
    logic [OFF_W-1:0]  off;
    logic [7:0]        data;
  } cmd_beat_t;

  typedef struct {
    cmd_beat_t  beat;
    bit         typed;
    logic [7:0] typed_val;
  } dir_row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [ACT_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;

  // Predictor state: table bytes, parity words, active row count.
  logic [7:0]       gf_table [256];
  logic [WORD_W-1:0] parity_mem [MAX_LENGTH];
  logic [ACT_W-1:0] active_cnt = 4'd1;
  bit               tbl_ok [256];
  bit [MAX_ROWS-1:0] par_ok [MAX_LENGTH];

  logic [7:0]       parity_expect_q [$];
  dir_row_t         dir_rows [$];
  logic [OFF_W-1:0] offset_pool [16];
  logic [ACT_W-1:0] row_settings [NUM_PHASES];

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  hold_rx = 1'b0;

  gf256_parity_accumulate_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic predict_beat(input cmd_beat_t it, output bit has_res,
                              output logic [7:0] res);
    int n;
    logic [7:0] lo, hi;
    logic [WORD_W-1:0] prod;
    has_res = 1'b0;
    res = 8'h00;
    case (it.cmd)
      CMD_LOAD: begin
        gf_table[{it.row, it.tidx}] = it.data;
        tbl_ok[{it.row, it.tidx}] = 1'b1;
      end
      CMD_PRESET: begin
        parity_mem[it.off][it.row*8 +: 8] = it.data;
        par_ok[it.off][it.row] = 1'b1;
      end
      CMD_ACCUM: begin
        n = (active_cnt > MAX_ROWS) ? MAX_ROWS : active_cnt;
        prod = '0;
        for (int r = 0; r < n; r++) begin
          lo = gf_table[r*32 + it.data[3:0]];
          hi = gf_table[r*32 + 16 + it.data[7:4]];
          prod[r*8 +: 8] = lo ^ hi;
        end
        parity_mem[it.off] = parity_mem[it.off] ^ prod;
      end
      default: begin
        has_res = 1'b1;
        res = parity_mem[it.off][it.row*8 +: 8];
      end
    endcase
  endtask

  // Offer one beat after a random gap, hold it until accepted, then predict.
  task automatic send_beat(input cmd_beat_t it, input bit typed, input logic [7:0] typed_val);
    int gap;
    bit has_res;
    logic [7:0] res;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.data, it.off, it.tidx, it.row, it.cmd};
    do @(posedge clk); while (!s_tready);
    predict_beat(it, has_res, res);
    if (has_res) parity_expect_q.push_back(typed ? typed_val : res);
  endtask

  task automatic add_dir(input cmd_t cmd, input int row, input int tidx, input int off,
                         input int data, input bit typed, input int typed_val);
    dir_row_t d;
    d.beat.cmd  = cmd;
    d.beat.row  = ROW_W'(row);
    d.beat.tidx = TIDX_W'(tidx);
    d.beat.off  = OFF_W'(off);
    d.beat.data = 8'(data);
    d.typed     = typed;
    d.typed_val = 8'(typed_val);
    dir_rows.push_back(d);
  endtask

  // Drain results, let the pipe settle, then write the row count.
  task automatic set_active_rows(input logic [ACT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (parity_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_cnt = value;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    cmd_beat_t it, pre;
    int pick, n, read_burst;
    logic [7:0] idx;
    read_burst = 0;
    n = (active_cnt > MAX_ROWS) ? MAX_ROWS : active_cnt;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (with_hold && k == 20) begin
        // stall the receiver and keep reads coming so the queue backs up
        hold_rx = 1'b1;
        read_burst = 24;
        tx_burst = 1'b1;
      end
      it.row  = ROW_W'($urandom_range(0, 7));
      it.tidx = TIDX_W'($urandom_range(0, 31));
      it.data = 8'($urandom_range(0, 255));
      it.off  = ($urandom_range(0, 9) == 0) ? OFF_W'($urandom_range(0, MAX_LENGTH - 1))
                                            : offset_pool[$urandom_range(0, 15)];
      pick = $urandom_range(0, 99);
      if (read_burst > 0) begin
        pick = 99;
        read_burst--;
        if (read_burst == 0) tx_burst = 1'b0;
      end
      if (pick < 15) it.cmd = CMD_LOAD;
      else if (pick < 30) it.cmd = CMD_PRESET;
      else if (pick < 70) it.cmd = CMD_ACCUM;
      else begin
        it.cmd = CMD_READ;
        if (n > 0 && $urandom_range(0, 3) != 0) it.row = ROW_W'($urandom_range(0, n - 1));
      end
      // write every table byte and parity byte this beat will look at
      pre = it;
      if (it.cmd == CMD_ACCUM) begin
        for (int r = 0; r < n; r++) begin
          for (int h = 0; h < 2; h++) begin
            idx = 8'(r*32 + (h ? 16 + it.data[7:4] : it.data[3:0]));
            if (!tbl_ok[idx]) begin
              pre.cmd  = CMD_LOAD;
              pre.row  = ROW_W'(r);
              pre.tidx = idx[4:0];
              pre.data = 8'($urandom_range(0, 255));
              send_beat(pre, 1'b0, 8'h00);
            end
          end
          if (!par_ok[it.off][r]) begin
            pre.cmd  = CMD_PRESET;
            pre.row  = ROW_W'(r);
            pre.data = 8'($urandom_range(0, 255));
            send_beat(pre, 1'b0, 8'h00);
          end
        end
      end else if (it.cmd == CMD_READ && !par_ok[it.off][it.row]) begin
        pre.cmd  = CMD_PRESET;
        pre.data = 8'($urandom_range(0, 255));
        send_beat(pre, 1'b0, 8'h00);
      end
      send_beat(it, 1'b0, 8'h00);
    end
  endtask

  // Receiver: random hold-off per beat, plus one long stall on request.
  initial begin : rx_side
    int gap, served;
    bit rx_burst;
    served = 0;
    rx_burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (served % 30 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 19);
      if (hold_rx) begin
        hold_rx = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      served++;
    end
  end

  always @(posedge clk) begin : check_results
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (parity_expect_q.size() == 0) begin
        report_mismatch($sformatf("result beat 0x%02h with nothing expected", m_tdata));
      end else begin
        want = parity_expect_q.pop_front();
        if (m_tdata !== want)
          report_mismatch($sformatf("parity_value got 0x%02h want 0x%02h", m_tdata, want));
      end
    end
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("gf256_parity_accumulate_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 256; i++) begin
      gf_table[i] = 8'h00;
      tbl_ok[i] = 1'b0;
    end
    for (int i = 0; i < MAX_LENGTH; i++) begin
      parity_mem[i] = '0;
      par_ok[i] = '0;
    end
    offset_pool[0] = '0;
    offset_pool[1] = OFF_W'(MAX_LENGTH - 1);
    for (int i = 2; i < 16; i++) offset_pool[i] = OFF_W'($urandom_range(0, MAX_LENGTH - 1));
    row_settings = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd9, 4'd3, 4'd8};
    row_settings[6] = ACT_W'($urandom_range(1, MAX_ROWS));

    // Directed rows, run with the reset row count of one.
    add_dir(CMD_LOAD,   0,  0,    0, 8'h00, 1'b0, 0);
    add_dir(CMD_LOAD,   0, 16,    0, 8'h00, 1'b0, 0);
    add_dir(CMD_LOAD,   0, 15, 2047, 8'hff, 1'b0, 0);
    add_dir(CMD_LOAD,   0, 31,    0, 8'h0f, 1'b0, 0);
    add_dir(CMD_LOAD,   7, 31, 2047, 8'hff, 1'b0, 0);
    add_dir(CMD_LOAD,   7,  0,    0, 8'h5a, 1'b0, 0);
    add_dir(CMD_PRESET, 0,  0,    0, 8'h00, 1'b0, 0);
    add_dir(CMD_PRESET, 7, 31, 2047, 8'hff, 1'b0, 0);
    add_dir(CMD_PRESET, 0,  0, 2047, 8'ha5, 1'b0, 0);
    add_dir(CMD_READ,   0,  0,    0, 8'hff, 1'b1, 8'h00);
    add_dir(CMD_READ,   7, 31, 2047, 8'h00, 1'b1, 8'hff);
    add_dir(CMD_READ,   0,  0, 2047, 8'h00, 1'b1, 8'ha5);
    add_dir(CMD_ACCUM,  7, 31,    0, 8'h00, 1'b0, 0);
    add_dir(CMD_ACCUM,  0,  0, 2047, 8'hff, 1'b0, 0);
    add_dir(CMD_READ,   0,  0, 2047, 8'h00, 1'b0, 0);
    add_dir(CMD_READ,   7,  0, 2047, 8'h00, 1'b1, 8'hff);
    add_dir(CMD_READ,   0, 31,    0, 8'h00, 1'b0, 0);
    add_dir(CMD_PRESET, 3,  0, 1024, 8'h3c, 1'b0, 0);
    add_dir(CMD_READ,   3,  0, 1024, 8'h00, 1'b1, 8'h3c);
    add_dir(CMD_ACCUM,  0,  0,    0, 8'h0f, 1'b0, 0);
    add_dir(CMD_READ,   0,  0,    0, 8'h00, 1'b0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].typed_val);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_active_rows(row_settings[p]);
      run_random(PHASE_BEATS, p == 0 || p == 4);
    end

    s_tvalid <= 1'b0;
    while (parity_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gf256_parity_accumulate_unit regression: pass");
    end else begin
      $display("gf256_parity_accumulate_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gpa_pkg.sv
rtl/core/gpa_front.sv
rtl/core/gpa_back.sv
rtl/core/gf256_parity_accumulate_unit.sv
tb/gf256_parity_accumulate_unit_tb.sv
